@@ sv/pdsc_pkg.sv @@
package pdsc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_KP_GAIN     = 3'd0;
	localparam logic [2:0] REG_KD_GAIN     = 3'd1;
	localparam logic [2:0] REG_PWM_TOP     = 3'd2;
	localparam logic [2:0] REG_DRIVE_FLOOR = 3'd3;
	localparam logic [2:0] REG_BOARD_ID    = 3'd4;

	// reset values
	localparam logic signed [15:0] KP_RESET    = 16'sd384;
	localparam logic signed [15:0] KD_RESET    = 16'sd128;
	localparam logic [14:0]        TOP_RESET   = 15'd255;
	localparam logic signed [15:0] FLOOR_RESET = -16'sd255;
	localparam logic [2:0]         BOARD_RESET = 3'd0;

	// direction codes
	localparam logic [1:0] DIR_STOP  = 2'd0;
	localparam logic [1:0] DIR_AHEAD = 2'd1;
	localparam logic [1:0] DIR_BACK  = 2'd2;

	// board identities with a sign rule
	localparam logic [2:0] BOARD_NEG_RATE  = 3'd1;
	localparam logic [2:0] BOARD_NEG_DRIVE = 3'd3;
	localparam logic [2:0] BOARD_NEG_BOTH  = 3'd5;
	localparam logic [2:0] BOARD_FIRST     = 3'd1;
	localparam logic [2:0] BOARD_LAST      = 3'd6;

	typedef struct packed {
		logic signed [15:0] kp_gain;
		logic signed [15:0] kd_gain;
		logic [14:0]        pwm_top;
		logic signed [15:0] drive_floor;
		logic [2:0]         board_id;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // take a word, clamp accumulator, form error terms
		logic mul;        // register x * gain
		logic div_start;  // load divider with |x| << F
		logic div_step;   // one restoring division step
		logic add;        // fold the term into the working accumulator
		logic finish;     // saturate and store accumulator
		logic term;       // 0: proportional, 1: derivative
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic board_ok;
		logic gain_neg;
		logic div_last;
	} sts_t;

	typedef struct packed {
		logic [1:0]         direction;
		logic [14:0]        duty;
		logic signed [15:0] drive_value;
	} res_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_START  = 6'b000010,
		ST_DIV    = 6'b000100,
		ST_ADD    = 6'b001000,
		ST_FINISH = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	function automatic logic board_valid(input logic [2:0] id);
		return (id >= BOARD_FIRST) && (id <= BOARD_LAST);
	endfunction

	function automatic logic board_neg_rate(input logic [2:0] id);
		return (id == BOARD_NEG_RATE) || (id == BOARD_NEG_BOTH);
	endfunction

	function automatic logic board_neg_drive(input logic [2:0] id);
		return (id == BOARD_NEG_DRIVE) || (id == BOARD_NEG_BOTH);
	endfunction

endpackage

@@ sv/motor_pd_speed_controller_unit.sv @@
// Incremental PD speed controller, one control tick per input word.
// Input stream (s_*): one word = target speed and raw measured rate.
// Output stream (m_*): one word = direction, clamped duty, signed drive.
// Config port: cfg_we/cfg_index/cfg_data, written only while the block is idle
//   by the user (not enforced); index 0 kp, 1 kd, 2 pwm_top, 3 drive floor,
//   4 board_id; others ignored. A word arriving while board_id is not 1..6 is
//   taken and dropped: no result, accumulator and previous error untouched.
// Term steps: a non-negative gain takes a multiply, then an add; a negative
//   gain runs a restoring divider, 1 quotient bit per cycle, then the add.
//   After both terms the accumulator is saturated and stored, the result is
//   loaded into the output register, and the block goes idle to take the next
//   word. One word is worked at a time.
// Output register: a finished word waits there; if m_tready is low when the
//   next result is done, the controller holds it until the register frees.
// Reset (arst_n low): config back to defaults, accumulator and previous error
//   cleared, output register empty.
module motor_pd_speed_controller_unit #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] target_speed, [31:16] measured_rate
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] direction, [16:2] duty, [32:17] drive_value
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pdsc_pkg::cfg_t cfg_q;
	pdsc_pkg::cmd_t cmd;
	pdsc_pkg::sts_t sts;
	pdsc_pkg::res_t res;
	pdsc_pkg::res_t out_q;
	logic           out_valid_q;
	logic           out_free;
	logic           emit;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain     <= pdsc_pkg::KP_RESET;
			cfg_q.kd_gain     <= pdsc_pkg::KD_RESET;
			cfg_q.pwm_top     <= pdsc_pkg::TOP_RESET;
			cfg_q.drive_floor <= pdsc_pkg::FLOOR_RESET;
			cfg_q.board_id    <= pdsc_pkg::BOARD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdsc_pkg::REG_KP_GAIN:     cfg_q.kp_gain     <= cfg_data;
				pdsc_pkg::REG_KD_GAIN:     cfg_q.kd_gain     <= cfg_data;
				pdsc_pkg::REG_PWM_TOP:     cfg_q.pwm_top     <= cfg_data[14:0];
				pdsc_pkg::REG_DRIVE_FLOOR: cfg_q.drive_floor <= cfg_data;
				pdsc_pkg::REG_BOARD_ID:    cfg_q.board_id    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// output slot frees when empty or being taken this cycle
	assign out_free = !out_valid_q || m_tready;

	// result is loaded in the emit state (controller leaves it when out_free)
	pdsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.out_load (emit),
		.cmd      (cmd)
	);

	pdsc_datapath #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.target_speed  (s_tdata[15:0]),
		.measured_rate (s_tdata[31:16]),
		.sts           (sts),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.drive_value, out_q.duty, out_q.direction};

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result loaded over a waiting word");
	a_drop_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !sts.board_ok) |=> s_tready)
		else $error("word for disabled board started work");
`endif

endmodule

@@ sv/pdsc_ctrl.sv @@
module pdsc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_free,
	input  pdsc_pkg::sts_t   sts,
	output logic             in_ready,
	output logic             out_load,
	output pdsc_pkg::cmd_t   cmd
);

	pdsc_pkg::state_t state_q, state_d;
	logic term_q, term_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdsc_pkg::ST_IDLE;
			term_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			term_q  <= term_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		term_d   = term_q;
		cmd      = '0;
		cmd.term = term_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			pdsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				// words for a disabled board are taken and dropped
				if (in_valid && sts.board_ok) begin
					cmd.load = 1'b1;
					term_d   = 1'b0;
					state_d  = pdsc_pkg::ST_START;
				end
			end
			pdsc_pkg::ST_START: begin
				if (sts.gain_neg) begin
					cmd.div_start = 1'b1;
					state_d       = pdsc_pkg::ST_DIV;
				end else begin
					cmd.mul = 1'b1;
					state_d = pdsc_pkg::ST_ADD;
				end
			end
			pdsc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = pdsc_pkg::ST_ADD;
				end
			end
			pdsc_pkg::ST_ADD: begin
				cmd.add = 1'b1;
				if (term_q) begin
					state_d = pdsc_pkg::ST_FINISH;
				end else begin
					term_d  = 1'b1;
					state_d = pdsc_pkg::ST_START;
				end
			end
			pdsc_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = pdsc_pkg::ST_EMIT;
			end
			pdsc_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = pdsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdsc_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_div_needs_neg_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pdsc_pkg::ST_DIV) |-> sts.gain_neg)
		else $error("divider running for a non-negative gain");
`endif

endmodule

@@ sv/pdsc_datapath.sv @@
module pdsc_datapath #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdsc_pkg::cmd_t        cmd,
	input  pdsc_pkg::cfg_t        cfg,
	input  logic signed [15:0]    target_speed,
	input  logic signed [15:0]    measured_rate,
	output pdsc_pkg::sts_t        sts,
	output pdsc_pkg::res_t        res
);

	localparam int F   = GAIN_FRAC_BITS;
	localparam int PW  = 35;                       // 19 x 16 product
	localparam int NW  = 19 + F;                   // divider numerator |x| << F
	localparam int QW  = (NW > PW) ? NW : PW;
	localparam int AW  = QW + 2;                   // working accumulator
	localparam int CW  = $clog2(NW);
	localparam int RW  = 17;                       // divider remainder
	localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);
	localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

	// state
	logic signed [15:0]    acc_q;
	logic signed [17:0]    perr_q;
	// working registers
	logic signed [AW-1:0]  work_q;
	logic signed [17:0]    e_q;
	logic signed [18:0]    d_q;
	logic signed [PW-1:0]  prod_q;
	logic [NW-1:0]         quo_q;
	logic [RW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  xneg_q;

	logic signed [16:0]    rate_eff, acc_ext, top_s, clamp_v;
	logic signed [17:0]    e_new;
	logic signed [18:0]    d_new, x_sel;
	logic [18:0]           x_abs;
	logic signed [15:0]    gain_sel;
	logic signed [16:0]    gain_neg17;
	logic [16:0]           mag;
	logic [RW:0]           trial;
	logic                  ge;
	logic signed [PW-1:0]  prod_sh;
	logic signed [AW-1:0]  q_term, q_mag, sum, work_add;
	logic                  rnz;
	logic signed [15:0]    sat_v;

	// entry: sign rule, error terms, clamp of stored accumulator
	always_comb begin
		rate_eff = pdsc_pkg::board_neg_rate(cfg.board_id) ?
			-{measured_rate[15], measured_rate} : {measured_rate[15], measured_rate};
		e_new   = {{2{target_speed[15]}}, target_speed} - {rate_eff[16], rate_eff};
		d_new   = {e_new[17], e_new} - {perr_q[17], perr_q};
		acc_ext = {acc_q[15], acc_q};
		top_s   = {2'b00, cfg.pwm_top};
		if ((acc_ext < top_s) && (acc_ext > -top_s)) begin
			clamp_v = acc_ext;
		end else if (acc_ext < 0) begin
			clamp_v = -top_s;
		end else begin
			clamp_v = top_s;
		end
	end

	// term operands
	always_comb begin
		x_sel      = cmd.term ? d_q : {e_q[17], e_q};
		x_abs      = x_sel[18] ? 19'(-x_sel) : 19'(x_sel);
		gain_sel   = cmd.term ? cfg.kd_gain : cfg.kp_gain;
		gain_neg17 = -{gain_sel[15], gain_sel};
		mag        = gain_neg17;
		trial      = {rem_q, quo_q[NW-1]};
		ge         = trial >= {1'b0, mag};
	end

	// fold one term: trunc(work + N/D) from the floored quotient or shifted product and a remainder flag; saturate work
	always_comb begin
		prod_sh = prod_q >>> F;
		q_mag   = {{(AW-NW){1'b0}}, quo_q};
		if (gain_sel[15]) begin
			rnz    = |rem_q;
			q_term = xneg_q ? (-q_mag - AW'(rnz)) : q_mag;
		end else begin
			rnz    = |prod_q[F-1:0];
			q_term = {{(AW-PW){prod_sh[PW-1]}}, prod_sh};
		end
		sum      = work_q + q_term;
		work_add = ((sum < 0) && rnz) ? sum + AW'(1) : sum;
		if (work_q > SAT_HI) begin
			sat_v = 16'sh7fff;
		end else if (work_q < SAT_LO) begin
			sat_v = 16'sh8000;
		end else begin
			sat_v = work_q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			perr_q <= '0;
		end else begin
			if (cmd.load) begin
				perr_q <= e_new;
			end
			if (cmd.finish) begin
				acc_q <= sat_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= {{(AW-17){clamp_v[16]}}, clamp_v};
			e_q    <= e_new;
			d_q    <= d_new;
		end else if (cmd.add) begin
			work_q <= work_add;
		end
		if (cmd.mul) begin
			prod_q <= x_sel * gain_sel;
		end
		if (cmd.div_start) begin
			quo_q  <= {x_abs, {F{1'b0}}};
			rem_q  <= '0;
			cnt_q  <= CNT_LAST;
			xneg_q <= x_sel[18];
		end else if (cmd.div_step) begin
			rem_q <= ge ? RW'(trial - {1'b0, mag}) : RW'(trial);
			quo_q <= {quo_q[NW-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign sts.board_ok = pdsc_pkg::board_valid(cfg.board_id);
	assign sts.gain_neg = gain_sel[15];
	assign sts.div_last = (cnt_q == '0);

	// result from stored accumulator
	logic signed [16:0] drv17, duty17;
	logic signed [15:0] drive, clamped;

	always_comb begin
		drv17   = pdsc_pkg::board_neg_drive(cfg.board_id) ? -acc_ext : acc_ext;
		drive   = (drv17 > 17'sd32767) ? 16'sh7fff : drv17[15:0];
		clamped = drive;
		duty17  = '0;
		res.drive_value = drive;
		if (drive < 0) begin
			clamped = (drive < cfg.drive_floor) ? cfg.drive_floor : drive;
			duty17  = -{clamped[15], clamped};
			res.direction = pdsc_pkg::DIR_BACK;
			if (duty17 < 0) begin
				res.duty = '0;
			end else if (duty17 > 17'sd32767) begin
				res.duty = 15'h7fff;
			end else begin
				res.duty = duty17[14:0];
			end
		end else if (drive > 0) begin
			res.direction = pdsc_pkg::DIR_AHEAD;
			res.duty = ({1'b0, drive[14:0]} > {1'b0, cfg.pwm_top}) ? cfg.pwm_top : drive[14:0];
		end else begin
			res.direction = pdsc_pkg::DIR_STOP;
			res.duty      = '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_clamp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (work_q <= $signed({{(AW-15){1'b0}}, cfg.pwm_top}))
			&& (work_q >= -$signed({{(AW-15){1'b0}}, cfg.pwm_top})))
		else $error("clamped accumulator outside pwm_top");
`endif

endmodule

@@ dv/tb_motor_pd_speed_controller_unit.sv @@
`timescale 1ns / 1ps

// Tracks the controller's accumulator and previous error, predicts the drive
// word for every accepted tick on an enabled board and checks the words coming out.
class pd_scoreboard;
	localparam int FRAC_BITS = 8;

	int               kp;
	int               kd;
	int               top;
	int               bottom;
	logic [2:0]       board;
	longint           acc;
	longint           prev_err;
	pdsc_pkg::res_t   drive_exp_q[$];
	int               mismatches;

	function new();
		kp         = pdsc_pkg::KP_RESET;
		kd         = pdsc_pkg::KD_RESET;
		top        = pdsc_pkg::TOP_RESET;
		bottom     = pdsc_pkg::FLOOR_RESET;
		board      = pdsc_pkg::BOARD_RESET;
		acc        = 0;
		prev_err   = 0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			pdsc_pkg::REG_KP_GAIN:     kp = $signed(val);
			pdsc_pkg::REG_KD_GAIN:     kd = $signed(val);
			pdsc_pkg::REG_PWM_TOP:     top = val[14:0];
			pdsc_pkg::REG_DRIVE_FLOOR: bottom = $signed(val);
			pdsc_pkg::REG_BOARD_ID:    board = val[2:0];
			default: ;
		endcase
	endfunction

	// exact add of x*gain/2^FRAC_BITS (or x*2^FRAC_BITS/|gain|), truncated toward zero
	function longint add_scaled(longint base, longint x, int gain);
		longint one;
		longint mag;
		one = longint'(1) << FRAC_BITS;
		if (gain < 0) begin
			mag = -longint'(gain);
			return (base * mag + x * one) / mag;
		end
		return (base * one + x * longint'(gain)) / one;
	endfunction

	function void take_tick(logic [31:0] word);
		longint         tgt;
		longint         rate;
		longint         err;
		longint         last;
		longint         sum;
		longint         drive;
		longint         duty;
		pdsc_pkg::res_t exp_word;
		if (board < pdsc_pkg::BOARD_FIRST || board > pdsc_pkg::BOARD_LAST)
			return;
		tgt  = longint'($signed(word[15:0]));
		rate = longint'($signed(word[31:16]));
		if (board == pdsc_pkg::BOARD_NEG_RATE || board == pdsc_pkg::BOARD_NEG_BOTH)
			rate = -rate;    // -32768 becomes +32768, error is 18 bits

		sum = acc;
		if (!(sum < top && sum > -top))
			sum = (sum < 0) ? -top : top;

		err      = tgt - rate;
		last     = prev_err;
		prev_err = err;
		sum = add_scaled(sum, err, kp);
		sum = add_scaled(sum, err - last, kd);
		if (sum > 32767)
			sum = 32767;
		if (sum < -32768)
			sum = -32768;
		acc = sum;

		drive = sum;
		if (board == pdsc_pkg::BOARD_NEG_DRIVE || board == pdsc_pkg::BOARD_NEG_BOTH) begin
			drive = -drive;
			if (drive > 32767)
				drive = 32767;
		end

		if (drive < 0) begin
			duty = (drive < bottom) ? -bottom : -drive;
			if (duty < 0)
				duty = 0;
			if (duty > 32767)
				duty = 32767;
			exp_word.direction = pdsc_pkg::DIR_BACK;
		end else if (drive > 0) begin
			duty = (drive > top) ? top : drive;
			exp_word.direction = pdsc_pkg::DIR_AHEAD;
		end else begin
			duty = 0;
			exp_word.direction = pdsc_pkg::DIR_STOP;
		end
		exp_word.duty        = duty[14:0];
		exp_word.drive_value = drive[15:0];
		drive_exp_q.push_back(exp_word);
	endfunction

	function void check_drive(logic [39:0] word);
		pdsc_pkg::res_t got;
		pdsc_pkg::res_t want;
		got.direction   = word[1:0];
		got.duty        = word[16:2];
		got.drive_value = word[32:17];
		if (drive_exp_q.size() == 0) begin
			$display("%0t: unexpected drive word %h", $time, word);
			mismatches++;
			return;
		end
		want = drive_exp_q.pop_front();
		if (got.direction !== want.direction) begin
			$display("%0t: direction expected %0d actual %0d", $time,
				want.direction, got.direction);
			mismatches++;
		end
		if (got.duty !== want.duty) begin
			$display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
			mismatches++;
		end
		if (got.drive_value !== want.drive_value) begin
			$display("%0t: drive_value expected %0d actual %0d", $time,
				want.drive_value, got.drive_value);
			mismatches++;
		end
	endfunction

	function int pending();
		return drive_exp_q.size();
	endfunction
endclass

module tb_motor_pd_speed_controller_unit;

	// worst tick: two negative gains, both terms through the divider; keep margin
	localparam int SETTLE_CYCLES  = 80;
	// cycles without any accepted word before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_TICKS   = 1900;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;      // [15:0] target_speed, [31:16] measured_rate
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;      // [1:0] direction, [16:2] duty, [32:17] drive_value
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	pd_scoreboard sb;

	int src_gap_pct;           // chance in 100 that the sender idles a cycle
	int sink_stall_pct;        // chance in 100 that the receiver stalls a cycle
	int idle_cycles;

	motor_pd_speed_controller_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// input side: every accepted word advances the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.take_tick(s_tdata);
	end

	// output side: every accepted word is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_drive(m_tdata);
	end

	// hang detection: counts cycles in which neither side moves a word
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** motor_pd_speed_controller_unit: FAILED **");
			$finish;
		end
	end

	// Offer one word; called and returns at a falling edge. tvalid is left
	// high so back-to-back words need no dip; callers drop it via quiet().
	task automatic send_word(input logic [15:0] tgt, input logic [15:0] rate);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rate, tgt};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic quiet();
		s_tvalid <= 1'b0;
	endtask

	// wait for all predicted words; with settle, also give a dropped tick time
	task automatic drain(input bit settle);
		quiet();
		while (sb.pending() != 0)
			@(negedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// block must be idle: call drain(1) first
	task automatic configure(input logic [15:0] kp, input logic [15:0] kd,
			input logic [15:0] top, input logic [15:0] bottom,
			input logic [2:0] board);
		write_reg(pdsc_pkg::REG_KP_GAIN, kp);
		write_reg(pdsc_pkg::REG_KD_GAIN, kd);
		write_reg(pdsc_pkg::REG_PWM_TOP, top);
		write_reg(pdsc_pkg::REG_DRIVE_FLOOR, bottom);
		write_reg(pdsc_pkg::REG_BOARD_ID, {13'd0, board});
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(0, 1024));
			5: return 16'(-int'($urandom_range(1, 1024)));
			6, 7: return 16'(-int'($urandom_range(1, 64)));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_top();
		case ($urandom_range(5))
			0: return 16'd1;
			1: return 16'd32767;
			2: return 16'd255;
			3: return 16'($urandom_range(1, 32767));
			default: return 16'($urandom_range(1, 600));
		endcase
	endfunction

	function automatic logic [15:0] pick_bottom();
		case ($urandom_range(5))
			0: return 16'hffff;                      // -1
			1: return 16'(-32767);
			2: return 16'(-255);
			3: return 16'(-int'($urandom_range(1, 32767)));
			default: return 16'(-int'($urandom_range(1, 600)));
		endcase
	endfunction

	function automatic logic [2:0] pick_board();
		if ($urandom_range(9) == 0)
			return ($urandom_range(1) != 0) ? 3'd7 : 3'd0;
		return 3'($urandom_range(pdsc_pkg::BOARD_FIRST, pdsc_pkg::BOARD_LAST));
	endfunction

	function automatic logic [15:0] pick_speed();
		case ($urandom_range(5))
			0, 1: return 16'($urandom);
			2: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'hffff;
					default: return 16'h0000;
				endcase
			end
			default: return 16'(int'($urandom_range(0, 1000)) - 500);
		endcase
	endfunction

	// one random setting followed by a burst of ticks; returns ticks that count
	task automatic random_phase(output int counted);
		int          n_ticks;
		int          saved_gap;
		int          saved_stall;
		int          pause_at;
		logic [2:0]  board;
		logic [15:0] tgt;
		logic [15:0] rate;
		drain(1);
		board = pick_board();
		configure(pick_gain(), pick_gain(), pick_top(), pick_bottom(), board);
		n_ticks     = (board >= pdsc_pkg::BOARD_FIRST && board <= pdsc_pkg::BOARD_LAST) ?
			100 : 20;
		saved_gap   = src_gap_pct;
		saved_stall = sink_stall_pct;
		pause_at    = ($urandom_range(3) == 0) ? int'($urandom_range(10, 90)) : -1;
		for (int i = 0; i < n_ticks; i++) begin
			// a stretch with no idling on either side
			if (i == 60) begin
				src_gap_pct    = 0;
				sink_stall_pct = 0;
			end
			if (i == 80) begin
				src_gap_pct    = saved_gap;
				sink_stall_pct = saved_stall;
			end
			if (i == pause_at)
				drain(0);
			tgt = pick_speed();
			// mostly a rate that tracks the target, as in closed loop
			if ($urandom_range(3) != 0)
				rate = tgt + 16'(int'($urandom_range(0, 128)) - 64);
			else
				rate = pick_speed();
			send_word(tgt, rate);
		end
		src_gap_pct    = saved_gap;
		sink_stall_pct = saved_stall;
		counted = (n_ticks == 100) ? n_ticks : 0;
	endtask

	initial begin
		int counted;
		int ticks_done;
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		idle_cycles    = 0;
		src_gap_pct    = 8;
		sink_stall_pct = 49;
		ticks_done     = 0;
		sb             = new();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// board 0 out of reset: ticks are dropped, nothing comes out
		send_word(16'd100, 16'd0);
		send_word(16'h8000, 16'h7fff);
		drain(1);

		// defaults on a plain board: zero drive, both signs, full-scale fields
		configure(pdsc_pkg::KP_RESET, pdsc_pkg::KD_RESET, 16'd255, pdsc_pkg::FLOOR_RESET,
			3'd2);
		send_word(16'd0, 16'd0);
		send_word(16'd100, 16'd0);
		send_word(16'hff9c, 16'd0);
		send_word(16'h7fff, 16'h8000);
		send_word(16'h8000, 16'h7fff);
		send_word(16'd0, 16'd0);
		drain(1);

		// negated rate: -32768 turns into +32768 in the 18-bit error
		configure(pdsc_pkg::KP_RESET, pdsc_pkg::KD_RESET, 16'd255, pdsc_pkg::FLOOR_RESET,
			pdsc_pkg::BOARD_NEG_RATE);
		send_word(16'd0, 16'h8000);
		send_word(16'h8000, 16'h8000);
		send_word(16'h7fff, 16'h7fff);
		drain(1);

		// huge gain saturates the accumulator; negated -32768 drive -> 32767
		configure(16'h7fff, 16'h7fff, 16'd32767, 16'(-32767), pdsc_pkg::BOARD_NEG_DRIVE);
		send_word(16'h8000, 16'h7fff);
		send_word(16'h8000, 16'h7fff);
		send_word(16'h7fff, 16'h8000);
		drain(1);

		// zero pwm_top: accumulator clamps to 0, forward drive has zero duty
		configure(pdsc_pkg::KP_RESET, pdsc_pkg::KD_RESET, 16'd0, pdsc_pkg::FLOOR_RESET,
			3'd4);
		send_word(16'd100, 16'd0);
		send_word(16'hff9c, 16'd0);
		drain(1);

		// both gains negative (divide), both sign rules, shallowest drive floor
		configure(16'h8000, 16'hffff, 16'd32767, 16'hffff, pdsc_pkg::BOARD_NEG_BOTH);
		send_word(16'd1000, 16'hfffb);
		send_word(16'h8000, 16'h8000);
		send_word(16'h7fff, 16'd0);
		drain(1);

		configure(16'hfffd, 16'd0, 16'd1, pdsc_pkg::FLOOR_RESET, 3'd6);
		send_word(16'd300, 16'd7);
		send_word(16'hfd00, 16'd0);
		drain(1);

		// board 7 disables control again
		configure(pdsc_pkg::KP_RESET, pdsc_pkg::KD_RESET, 16'd255, pdsc_pkg::FLOOR_RESET,
			3'd7);
		send_word(16'd5, 16'd1);
		send_word(16'hffff, 16'd0);

		// random settings: three idling profiles in turn
		while (ticks_done < RANDOM_TICKS / 3) begin
			random_phase(counted);
			ticks_done += counted;
		end
		src_gap_pct    = 49;
		sink_stall_pct = 8;
		while (ticks_done < 2 * RANDOM_TICKS / 3) begin
			random_phase(counted);
			ticks_done += counted;
		end
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		while (ticks_done < RANDOM_TICKS) begin
			random_phase(counted);
			ticks_done += counted;
		end

		// let everything come out, then watch a while for stray words
		drain(1);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("** motor_pd_speed_controller_unit: PASSED **");
		end else begin
			if (sb.pending() != 0)
				$display("%0t: %0d expected drive words never came", $time, sb.pending());
			$display("** motor_pd_speed_controller_unit: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/pdsc_pkg.sv
sv/pdsc_ctrl.sv
sv/pdsc_datapath.sv
sv/motor_pd_speed_controller_unit.sv
dv/tb_motor_pd_speed_controller_unit.sv
